/* hdl/itb_pkg.sv */
// itb_pkg: shared types and constants for the interval timer bank.
// Holds the request/result words and the word that travels the cell chain.
// No dependencies.
`timescale 1ns / 1ps

package itb_pkg;

    // Widest bank the chain word is sized for.
    localparam int unsigned MAX_TIMERS = 16;
    localparam int unsigned ID_W       = 4;
    localparam int unsigned TIME_W     = 64;
    localparam int unsigned INTV_W     = 48;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_SET    = 3'd1;
    localparam logic [2:0] MODE_CANCEL = 3'd2;
    localparam logic [2:0] MODE_ADJUST = 3'd3;
    localparam logic [2:0] MODE_POLL   = 3'd4;

    typedef struct packed {
        logic [2:0]               mode;
        logic [1:0]               timer_index;
        logic signed [INTV_W-1:0] interval;
    } request_t;

    typedef struct packed {
        logic       event_valid;
        logic [1:0] event_timer;
        logic [3:0] running_mask;
    } result_t;

    // One command on its way down the chain. value is the new time on a tick,
    // the expiry time on a set and the delta on an adjust.
    typedef struct packed {
        logic                  valid;
        logic [2:0]            mode;
        logic [1:0]            timer_index;
        logic [TIME_W-1:0]     value;
        logic                  found;
        logic [ID_W-1:0]       found_id;
        logic [MAX_TIMERS-1:0] mask;
    } chain_word_t;

endpackage

/* hdl/itb_head.sv */
// itb_head: time counter and command launch into the timer chain.
// Depends on itb_pkg.
`timescale 1ns / 1ps

module itb_head (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  itb_pkg::request_t   request,
    output itb_pkg::chain_word_t word_out
);
    import itb_pkg::*;

    logic [TIME_W-1:0] time_now_reg, time_now_next;
    chain_word_t       word_reg, word_next;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] addend;
    logic [TIME_W-1:0] sum;

    assign delta  = {{(TIME_W - INTV_W){request.interval[INTV_W-1]}}, request.interval};
    assign addend = (request.mode == MODE_TICK) ? TIME_W'(1) : delta;
    assign sum    = time_now_reg + addend;

    always_comb
    begin
        time_now_next         = time_now_reg;
        word_next             = '0;
        word_next.valid       = accept;
        word_next.mode        = request.mode;
        word_next.timer_index = request.timer_index;
        case (request.mode)
            MODE_TICK:
            begin
                word_next.value = sum;
                if (accept)
                    time_now_next = sum;
            end
            MODE_SET:
                word_next.value = sum;
            MODE_ADJUST:
            begin
                word_next.value = delta;
                if (accept)
                    time_now_next = sum;
            end
            default:
                word_next.value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg <= '0;
            word_reg     <= '0;
        end
        else
        begin
            time_now_reg <= time_now_next;
            word_reg     <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

/* hdl/itb_cell.sv */
// itb_cell: one timer of the bank; applies each passing command and hands it on.
// Depends on itb_pkg.
`timescale 1ns / 1ps

module itb_cell #(
    parameter int unsigned CELL_ID = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  itb_pkg::chain_word_t word_in,
    output itb_pkg::chain_word_t word_out
);
    import itb_pkg::*;

    localparam logic [ID_W-1:0] ID = ID_W'(CELL_ID);

    logic [TIME_W-1:0] expiry_reg, expiry_next;
    logic              running_reg, running_next;
    logic              expired_reg, expired_next;
    chain_word_t       word_reg, word_next;
    logic [TIME_W-1:0] diff;
    logic              hit;

    assign diff = word_in.value - expiry_reg;
    assign hit  = ({2'b00, word_in.timer_index} == ID);

    always_comb
    begin
        expiry_next  = expiry_reg;
        running_next = running_reg;
        expired_next = expired_reg;
        word_next    = word_in;
        if (word_in.valid)
        begin
            case (word_in.mode)
                MODE_TICK:
                    // reached when the signed difference is not negative
                    if (running_reg && !diff[TIME_W-1])
                    begin
                        running_next = 1'b0;
                        expired_next = 1'b1;
                    end
                MODE_SET:
                    if (hit)
                    begin
                        expiry_next  = word_in.value;
                        running_next = 1'b1;
                        expired_next = 1'b0;
                    end
                MODE_CANCEL:
                    if (hit)
                    begin
                        running_next = 1'b0;
                        expired_next = 1'b0;
                    end
                MODE_ADJUST:
                    if (running_reg)
                        expiry_next = expiry_reg + word_in.value;
                MODE_POLL:
                    if (expired_reg && !word_in.found)
                    begin
                        expired_next       = 1'b0;
                        word_next.found    = 1'b1;
                        word_next.found_id = ID;
                    end
                default:
                    ;
            endcase
        end
        word_next.mask[CELL_ID] = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            expired_reg <= 1'b0;
            word_reg    <= '0;
        end
        else
        begin
            running_reg <= running_next;
            expired_reg <= expired_next;
            word_reg    <= word_next;
        end
    end

    // expiry is written by a set before it is ever compared
    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
    end

    assign word_out = word_reg;

endmodule

/* hdl/interval_timer_bank_top.sv */
// interval_timer_bank_top: bank of one-shot timers against a 64-bit time counter.
// Depends on itb_pkg, itb_head and itb_cell.
`timescale 1ns / 1ps
//
// Usage
//   A request word (mode, timer_index, interval) is taken at a rising edge
//   with start high and busy low. busy stays low: the chain takes a new word
//   every cycle, so throughput is one request per clock.
//   The head register holds the time counter; it applies tick and adjust to
//   the time at once and launches the word down a row of NUM_TIMERS cells,
//   one cell per timer. Each cell applies the word to its own timer and hands
//   it to the next cell on the following edge. A poll carries a found flag
//   down the row, so the lowest-numbered expired timer claims it first; the
//   running mask is built bit by bit the same way.
//   done rises once the word has passed the head register and then every
//   cell register in turn; it is high for a single cycle per result, and the
//   result word is valid while it is high. Results leave in request order,
//   one per request. The receiver cannot stall.
//   Reset (rst_n low, asynchronous) clears the time, all running and expired
//   marks and any words in flight. Expiry times are not reset.
//   When done is low, result reads as zero.
module interval_timer_bank_top #(
    parameter int unsigned NUM_TIMERS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  itb_pkg::request_t request,
    output logic              done,
    output itb_pkg::result_t  result
);
    import itb_pkg::*;

    chain_word_t chain [0:NUM_TIMERS];
    chain_word_t tail;

    // chain never backs up
    assign busy = 1'b0;

    itb_head u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (start && !busy),
        .request  (request),
        .word_out (chain[0])
    );

    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_cell
        itb_cell #(
            .CELL_ID (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .word_in  (chain[g]),
            .word_out (chain[g+1])
        );
    end

    assign tail = chain[NUM_TIMERS];
    assign done = tail.valid;

    always_comb
    begin
        result = '0;
        if (tail.valid)
        begin
            result.event_valid  = tail.found;
            result.event_timer  = tail.found_id[1:0];
            result.running_mask = tail.mask[3:0];
        end
    end

endmodule

/* hdl/itb_checker.sv */
// itb_checker: port-level assertions for interval_timer_bank_top, plus its bind.
// Depends on itb_pkg.
`timescale 1ns / 1ps

module itb_checker #(
    parameter int unsigned NUM_TIMERS = 4
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input itb_pkg::request_t request,
    input logic              done,
    input itb_pkg::result_t  result
);
    import itb_pkg::*;

    // each result answers a request taken a fixed time earlier
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, NUM_TIMERS + 1))
        else $error("result without a matching request");

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(NUM_TIMERS + 1) done)
        else $error("request produced no result");

    // an expired timer reported by a poll cannot be running
    a_event_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.event_valid) |-> !result.running_mask[result.event_timer])
        else $error("polled timer still shown running");

    // no timer beyond the bank may show as running
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.running_mask >> NUM_TIMERS) == 4'd0))
        else $error("running bit outside the bank");

endmodule

bind interval_timer_bank_top itb_checker #(.NUM_TIMERS(NUM_TIMERS)) u_itb_checker (.*);
